>>> rtl/fotk_pkg.sv
// shared types and codes for the frequency ordered key table
// no dependencies
package fotk_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int CNT_W           = 32;
  localparam int STATUS_W        = 3;
  localparam int POS_W           = 4;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_CMP,
    S_RESOLVE,
    S_RM_RD,
    S_RM_WR,
    S_MV_RD,
    S_MV_CHK,
    S_MV_PUT
  } state_t;

endpackage

>>> rtl/fotk_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module fotk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/frequency_ordered_key_table.sv
// Frequency ordered key table: up to TABLE_DEPTH key/value entries kept in
// non-increasing access-count order in one 96-bit wide ram. One operation is
// handled at a time. A key lookup walks the table one entry at a time (ram
// read, then compare) until the operation resolves; remove then pulls each
// entry behind the removed one a place toward the head to close the gap, and
// search moves past the entries whose count is below its incremented count,
// reads the entry that stops it when it does not reach the head, and then
// places the found entry. No clearing pass is needed after reset.
// depends on fotk_pkg and fotk_ram
module frequency_ordered_key_table
  import fotk_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic signed [31:0]  in_key,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic signed [31:0]  out_key_out,
  output logic signed [31:0]  out_value_out,
  output logic [31:0]         out_count_out,
  output logic [3:0]          out_position_out
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    pos_r, pos_nxt;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] val_r, val_nxt;
  logic [KEY_W-1:0] hval_r, hval_nxt;
  logic [CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic             hit_r, hit_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [KEY_W-1:0]    out_key_r, out_value_r;
  logic [CNT_W-1:0]    out_count_r;
  logic [IW-1:0]       out_pos_r;

  logic                ld;
  logic [STATUS_W-1:0] ld_status;
  logic [KEY_W-1:0]    ld_key, ld_value;
  logic [CNT_W-1:0]    ld_count;
  logic [IW-1:0]       ld_pos;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic in_xfer, key_match, scan_last, rm_last, rm_tail;

  fotk_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign in_xfer   = in_valid && !in_stall;
  assign key_match = (ram_rdata.key == key_r);
  assign scan_last = ({1'b0, idx_r} == OW'(occ_r - OW'(1)));
  assign rm_last   = ({1'b0, idx_r} == OW'(occ_r - OW'(1)));
  assign rm_tail   = (OW'({1'b0, pos_r} + OW'(1)) == occ_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_func != FN_UNUSED) begin
          state_nxt = (occ_r == '0) ? S_RESOLVE : S_SC_RD;
        end
      end
      S_SC_RD:  state_nxt = S_SC_CMP;
      S_SC_CMP: begin
        if (key_match || scan_last) state_nxt = S_RESOLVE;
        else                        state_nxt = S_SC_RD;
      end
      S_RESOLVE: begin
        state_nxt = S_IDLE;
        if (hit_r && func_r == FN_REMOVE && !rm_tail) state_nxt = S_RM_RD;
        if (hit_r && func_r == FN_SEARCH) begin
          state_nxt = (pos_r == '0) ? S_MV_PUT : S_MV_RD;
        end
      end
      S_RM_RD:  state_nxt = S_RM_WR;
      S_RM_WR:  state_nxt = rm_last ? S_IDLE : S_RM_RD;
      S_MV_RD:  state_nxt = S_MV_CHK;
      S_MV_CHK: begin
        if (ram_rdata.count < hcnt_r && idx_r != '0) state_nxt = S_MV_RD;
        else                                         state_nxt = S_MV_PUT;
      end
      S_MV_PUT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    occ_nxt   = occ_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    hval_nxt  = hval_r;
    hcnt_nxt  = hcnt_r;
    hit_nxt   = hit_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r;
    ld        = 1'b0;
    ld_status = ST_NOT_FOUND;
    ld_key    = key_r;
    ld_value  = '0;
    ld_count  = '0;
    ld_pos    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          func_nxt = in_func;
          key_nxt  = in_key;
          val_nxt  = in_value;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
        end
      end
      S_SC_CMP: begin
        if (key_match) begin
          hit_nxt  = 1'b1;
          pos_nxt  = idx_r;
          hval_nxt = ram_rdata.value;
          hcnt_nxt = ram_rdata.count;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_RESOLVE: begin
        case (func_r)
          FN_INSERT: begin
            ld = 1'b1;
            if (hit_r) begin
              ld_status = ST_EXISTS;
              ld_value  = hval_r;
              ld_count  = hcnt_r;
              ld_pos    = pos_r;
            end else if (occ_r == OW'(TABLE_DEPTH)) begin
              ld_status = ST_FULL;
              ld_value  = val_r;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = occ_r[IW-1:0];
              ram_wdata = '{key: key_r, value: val_r, count: '0};
              ld_status = ST_INSERTED;
              ld_value  = val_r;
              ld_pos    = occ_r[IW-1:0];
              occ_nxt   = occ_r + OW'(1);
            end
          end
          FN_REMOVE: begin
            ld = 1'b1;
            if (hit_r) begin
              ld_status = ST_REMOVED;
              ld_value  = hval_r;
              ld_count  = hcnt_r;
              ld_pos    = pos_r;
              idx_nxt   = pos_r + IW'(1);
              if (rm_tail) occ_nxt = occ_r - OW'(1);
            end
          end
          FN_SEARCH: begin
            if (hit_r) begin
              if (hcnt_r != CNT_MAX) hcnt_nxt = hcnt_r + CNT_W'(1);
              idx_nxt = pos_r - IW'(1);
            end else begin
              ld = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_RM_WR: begin
        // pull the entry one place toward the head
        ram_we    = 1'b1;
        ram_waddr = idx_r - IW'(1);
        if (rm_last) occ_nxt = occ_r - OW'(1);
        else         idx_nxt = idx_r + IW'(1);
      end
      S_MV_CHK: begin
        if (ram_rdata.count < hcnt_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r + IW'(1);
          if (idx_r == '0) pos_nxt = '0;
          else             idx_nxt = idx_r - IW'(1);
        end else begin
          pos_nxt = idx_r + IW'(1);
        end
      end
      S_MV_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = '{key: key_r, value: hval_r, count: hcnt_r};
        ld        = 1'b1;
        ld_status = ST_FOUND;
        ld_value  = hval_r;
        ld_count  = hcnt_r;
        ld_pos    = pos_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (ld)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    func_r <= func_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    hval_r <= hval_nxt;
    hcnt_r <= hcnt_nxt;
    hit_r  <= hit_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_key_r    <= ld_key;
      out_value_r  <= ld_value;
      out_count_r  <= ld_count;
      out_pos_r    <= ld_pos;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_key_out      = out_key_r;
  assign out_value_out    = out_value_r;
  assign out_count_out    = out_count_r;
  assign out_position_out = POS_W'(out_pos_r);

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(TABLE_DEPTH))
    else $error("occupancy beyond table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, ram_waddr} <= occ_r))
    else $error("write past the table tail");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> !out_valid_r)
    else $error("result loaded over a pending transfer");

endmodule
